/* design/json_record_field_indexer_assert.svh */
`ifndef JSON_RECORD_FIELD_INDEXER_ASSERT_SVH
`define JSON_RECORD_FIELD_INDEXER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define JRFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define JRFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/jrfi_pkg.sv */
package jrfi_pkg;

  localparam int OFFSET_W    = 16;
  localparam int FIELD_NUM_W = 6;
  localparam int FIELD_CNT_W = 7;
  localparam int MAX_FIELDS  = 64;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;

  localparam logic [2:0] DELIM_LEN_MIN = 3'd1;
  localparam logic [2:0] DELIM_LEN_MAX = 3'd4;

  localparam logic [OFFSET_W-1:0] NO_DELIM_OFFSET = '1;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] REG_DELIM_BYTES  = 2'd0;
  localparam logic [1:0] REG_DELIM_LEN    = 2'd1;
  localparam logic [1:0] REG_SCHEMA_COUNT = 2'd2;

  localparam logic [31:0] DELIM_BYTES_RST  = 32'd10;
  localparam logic [2:0]  DELIM_LEN_RST    = 3'd1;
  localparam logic [6:0]  SCHEMA_COUNT_RST = 7'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic                   record_kind;
    logic [FIELD_NUM_W-1:0] field_number;
    logic [OFFSET_W-1:0]    start_offset;
    logic [OFFSET_W-1:0]    end_offset;
    logic                   record_done;
    logic                   count_mismatch;
    logic                   delim_found;
    logic                   last_result;
  } result_t;

  typedef struct packed {
    logic [31:0] delim_bytes;
    logic [2:0]  delim_len;
    logic [6:0]  schema_count;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_NUM_W-1:0] num;
    logic [OFFSET_W-1:0]    start_off;
    logic [OFFSET_W-1:0]    end_off;
    logic                   done;
    logic                   mism;
  } field_evt_t;

  // everything one byte produces: a field result and/or a buffer summary
  typedef struct packed {
    logic                has_field;
    field_evt_t          fld;
    logic                has_summary;
    logic                delim_found;
    logic [OFFSET_W-1:0] first_off;
    logic [OFFSET_W-1:0] last_off;
  } event_t;

endpackage

/* design/jrfi_front.sv */
module jrfi_front import jrfi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  in_item_t item,
  input  logic     accept,
  output logic     evt_push,
  output event_t   evt
);

  logic [OFFSET_W-1:0]    pos, pos_next;
  logic [23:0]            recent, recent_next;
  logic [2:0]             bsm, bsm_next;
  logic                   in_records, in_records_next;
  logic [OFFSET_W-1:0]    rec_start, rec_start_next;
  logic [OFFSET_W-1:0]    fld_start, fld_start_next;
  logic                   in_value, in_value_next;
  logic [FIELD_CNT_W-1:0] fld_cnt, fld_cnt_next;
  logic [OFFSET_W-1:0]    first_off, first_off_next;
  logic [OFFSET_W-1:0]    last_off, last_off_next;

  logic [2:0]             len;
  logic [2:0]             cnt;
  logic [7:0]             win_b [4];
  logic [1:0]             idx;
  logic                   match;
  logic [7:0]             c;
  logic [OFFSET_W-1:0]    dstart;
  logic [FIELD_NUM_W-1:0] shown;

  always_comb begin
    if (cfg.delim_len < DELIM_LEN_MIN) begin
      len = DELIM_LEN_MIN;
    end else if (cfg.delim_len > DELIM_LEN_MAX) begin
      len = DELIM_LEN_MAX;
    end else begin
      len = cfg.delim_len;
    end
    cnt = (bsm == 3'd7) ? 3'd7 : bsm + 3'd1;

    // newest byte at index 0
    win_b[0] = item.data_byte;
    win_b[1] = recent[7:0];
    win_b[2] = recent[15:8];
    win_b[3] = recent[23:16];

    match = (cnt >= len);
    for (int i = 0; i < 4; i++) begin
      idx = 2'(32'(len) - 32'd1 - i);
      if ((i < 32'(len)) && (win_b[idx] != cfg.delim_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    c      = win_b[2'(len - 3'd1)];
    dstart = pos - OFFSET_W'(len - 3'd1);
    shown  = (fld_cnt < FIELD_CNT_W'(MAX_FIELDS)) ? fld_cnt[FIELD_NUM_W-1:0]
                                                   : FIELD_NUM_W'(MAX_FIELDS - 1);

    pos_next        = pos + OFFSET_W'(1);
    recent_next     = {recent[15:0], item.data_byte};
    bsm_next        = cnt;
    in_records_next = in_records;
    rec_start_next  = rec_start;
    fld_start_next  = fld_start;
    in_value_next   = in_value;
    fld_cnt_next    = fld_cnt;
    first_off_next  = first_off;
    last_off_next   = last_off;
    evt             = '0;

    if (match) begin
      if (in_records) begin
        evt.has_field     = 1'b1;
        evt.fld.num       = shown;
        evt.fld.start_off = in_value ? fld_start : rec_start;
        evt.fld.end_off   = dstart - OFFSET_W'(1);
        evt.fld.done      = 1'b1;
        evt.fld.mism      = !in_value ||
                            ((8'(fld_cnt) + 8'd1) != 8'(cfg.schema_count));
      end else begin
        first_off_next  = dstart;
        in_records_next = 1'b1;
      end
      last_off_next  = dstart;
      rec_start_next = pos + OFFSET_W'(1);
      in_value_next  = 1'b0;
      fld_cnt_next   = '0;
      bsm_next       = '0;
    end else if (in_records && (cnt >= len)) begin
      if (!in_value && (c == COLON_CHAR)) begin
        fld_start_next = dstart + OFFSET_W'(1);
        in_value_next  = 1'b1;
      end else if (in_value && (c == COMMA_CHAR)) begin
        evt.has_field     = 1'b1;
        evt.fld.num       = shown;
        evt.fld.start_off = fld_start;
        evt.fld.end_off   = dstart;
        if (fld_cnt < FIELD_CNT_W'(MAX_FIELDS)) begin
          fld_cnt_next = fld_cnt + FIELD_CNT_W'(1);
        end
        in_value_next = 1'b0;
      end
    end

    if (item.buffer_end) begin
      evt.has_summary = 1'b1;
      evt.delim_found = in_records_next;
      evt.first_off   = in_records_next ? first_off_next : NO_DELIM_OFFSET;
      evt.last_off    = in_records_next ? last_off_next : NO_DELIM_OFFSET;
      pos_next        = '0;
      recent_next     = '0;
      bsm_next        = '0;
      in_records_next = 1'b0;
      rec_start_next  = '0;
      fld_start_next  = '0;
      in_value_next   = 1'b0;
      fld_cnt_next    = '0;
      first_off_next  = '0;
      last_off_next   = '0;
    end
  end

  assign evt_push = accept && (evt.has_field || evt.has_summary);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      recent     <= '0;
      bsm        <= '0;
      in_records <= 1'b0;
      rec_start  <= '0;
      fld_start  <= '0;
      in_value   <= 1'b0;
      fld_cnt    <= '0;
      first_off  <= '0;
      last_off   <= '0;
    end else if (accept) begin
      pos        <= pos_next;
      recent     <= recent_next;
      bsm        <= bsm_next;
      in_records <= in_records_next;
      rec_start  <= rec_start_next;
      fld_start  <= fld_start_next;
      in_value   <= in_value_next;
      fld_cnt    <= fld_cnt_next;
      first_off  <= first_off_next;
      last_off   <= last_off_next;
    end
  end

endmodule

/* design/jrfi_queue.sv */
module jrfi_queue import jrfi_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   enq,
  input  event_t wdata,
  output logic   full,
  input  logic   deq,
  output logic   empty,
  output event_t rdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t             mem [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_enq;
  logic               do_deq;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rdata  = mem[rd_ptr];
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_enq && !do_deq) begin
        count <= count + CNT_W'(1);
      end else if (do_deq && !do_enq) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* design/jrfi_back.sv */
module jrfi_back import jrfi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  event_t  q_head,
  output logic    q_deq,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic part_sent;
  logic show_field;
  logic split;
  logic take;

  assign show_field = q_head.has_field && !part_sent;
  assign split      = show_field && q_head.has_summary;
  assign empty      = q_empty;
  assign take       = pop && !q_empty;
  assign q_deq      = take && !split;

  always_comb begin
    result = '0;
    if (show_field) begin
      result.record_kind    = KIND_FIELD;
      result.field_number   = q_head.fld.num;
      result.start_offset   = q_head.fld.start_off;
      result.end_offset     = q_head.fld.end_off;
      result.record_done    = q_head.fld.done;
      result.count_mismatch = q_head.fld.mism;
      result.last_result    = !q_head.has_summary;
    end else begin
      result.record_kind  = KIND_SUMMARY;
      result.start_offset = q_head.first_off;
      result.end_offset   = q_head.last_off;
      result.delim_found  = q_head.delim_found;
      result.last_result  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_sent <= 1'b0;
    end else if (take) begin
      part_sent <= split;
    end
  end

endmodule

/* design/json_record_field_indexer.sv */
// Record field indexer. Takes one buffer byte per cycle whenever full is low
// and reports, per record, the start and end offsets of each field (colon to
// comma, end exclusive; last field up to the delimiter, end inclusive), with
// a field count check on the closing field, plus a summary of first and last
// delimiter offsets on the byte that carries buffer_end. A byte is classified
// in the cycle it is accepted; its results wait in a QUEUE_DEPTH-entry queue
// and leave one per pop, so a byte that closes a field and also ends the
// buffer needs two pops. Sustained rate is one byte per cycle as long as pop
// keeps up; the output side sets the limit otherwise. Registers (APB, 4-byte
// stride): 0x0 delimiter bytes (first byte low, reset 0x0A), 0x4 delimiter
// length (1..4 after clamping, reset 1), 0x8 schema field count (reset 1).
module json_record_field_indexer import jrfi_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    item,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  logic   accept;
  logic   evt_push;
  event_t evt;
  logic   q_empty;
  event_t q_head;
  logic   q_deq;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim_bytes  <= DELIM_BYTES_RST;
      cfg.delim_len    <= DELIM_LEN_RST;
      cfg.schema_count <= SCHEMA_COUNT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DELIM_BYTES:  cfg.delim_bytes  <= pwdata;
        REG_DELIM_LEN:    cfg.delim_len    <= pwdata[2:0];
        REG_SCHEMA_COUNT: cfg.schema_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DELIM_BYTES:  prdata = cfg.delim_bytes;
      REG_DELIM_LEN:    prdata = {29'd0, cfg.delim_len};
      REG_SCHEMA_COUNT: prdata = {25'd0, cfg.schema_count};
      default:          prdata = '0;
    endcase
  end

  jrfi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .accept   (accept),
    .evt_push (evt_push),
    .evt      (evt)
  );

  jrfi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .enq   (evt_push),
    .wdata (evt),
    .full  (full),
    .deq   (q_deq),
    .empty (q_empty),
    .rdata (q_head)
  );

  jrfi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_deq   (q_deq),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

/* design/jrfi_checker.sv */
`include "json_record_field_indexer_assert.svh"

module jrfi_checker import jrfi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  `JRFI_ASSERT_NOW(a_empty_after_reset, $past(rst), empty, "queue not empty after reset")
  `JRFI_ASSERT_NOW(a_summary_clean, !empty && result.record_kind == KIND_SUMMARY, result.field_number == '0 && !result.record_done && !result.count_mismatch && result.last_result, "summary item carries field data")
  `JRFI_ASSERT_NOW(a_field_no_found, !empty && result.record_kind == KIND_FIELD, !result.delim_found, "field item has delim_found set")
  `JRFI_ASSERT_NOW(a_none_offsets, !empty && result.record_kind == KIND_SUMMARY && !result.delim_found, result.start_offset == NO_DELIM_OFFSET && result.end_offset == NO_DELIM_OFFSET, "summary without delimiter has offsets")
  `JRFI_ASSERT_NEXT(a_second_follows, pop && !empty && !result.last_result, !empty, "second item of a byte missing")

endmodule

bind json_record_field_indexer jrfi_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import jrfi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int QUIET_CYCLES = 16;
  localparam int BYTES_PER_SETTING = 100;
  localparam int REPORT_MAX = 10;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  json_record_field_indexer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // register copies
  logic [31:0] cfg_delim_bytes = DELIM_BYTES_RST;
  logic [2:0] cfg_delim_len = DELIM_LEN_RST;
  logic [6:0] cfg_schema = SCHEMA_COUNT_RST;

  // scanner state
  logic [15:0] scan_pos = '0;
  logic [23:0] recent_window = '0;
  int since_match = 0;
  logic in_records = 1'b0;
  logic [15:0] rec_start = '0;
  logic [15:0] fld_start = '0;
  logic in_value = 1'b0;
  int fld_count = 0;
  logic [15:0] first_delim = '0;
  logic [15:0] last_delim = '0;

  result_t expected_results[$];
  logic [7:0] pending[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int buffers_done = 0;
  int settings_applied = 0;
  int fields_checked = 0;
  int summaries_checked = 0;
  int cycle_count = 0;

  function automatic int eff_delim_len();
    if (cfg_delim_len < DELIM_LEN_MIN) return int'(DELIM_LEN_MIN);
    if (cfg_delim_len > DELIM_LEN_MAX) return int'(DELIM_LEN_MAX);
    return int'(cfg_delim_len);
  endfunction

  function automatic logic [FIELD_NUM_W-1:0] shown_field();
    if (fld_count < MAX_FIELDS) return FIELD_NUM_W'(fld_count);
    return FIELD_NUM_W'(MAX_FIELDS - 1);
  endfunction

  function automatic result_t make_result(logic kind, logic [FIELD_NUM_W-1:0] num,
                                          logic [OFFSET_W-1:0] s, logic [OFFSET_W-1:0] e,
                                          logic done, logic mism, logic found);
    result_t r;
    r.record_kind = kind;
    r.field_number = num;
    r.start_offset = s;
    r.end_offset = e;
    r.record_done = done;
    r.count_mismatch = mism;
    r.delim_found = found;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("kind=%0d num=%0d start=%0d end=%0d done=%0d mism=%0d found=%0d last=%0d",
                     r.record_kind, r.field_number, r.start_offset, r.end_offset,
                     r.record_done, r.count_mismatch, r.delim_found, r.last_result);
  endfunction

  task automatic clear_scan_state();
    scan_pos = '0;
    recent_window = '0;
    since_match = 0;
    in_records = 1'b0;
    rec_start = '0;
    fld_start = '0;
    in_value = 1'b0;
    fld_count = 0;
    first_delim = '0;
    last_delim = '0;
  endtask

  task automatic index_byte(input in_item_t it);
    logic [7:0] b, w, c;
    logic [15:0] p, dstart, q;
    int len, cnt, i;
    logic hit;
    result_t out_q[$];
    b = it.data_byte;
    p = scan_pos;
    len = eff_delim_len();
    cnt = (since_match >= 7) ? 7 : since_match + 1;
    hit = 1'b0;
    if (cnt >= len) begin
      hit = 1'b1;
      for (i = 0; i < len; i++) begin
        if (i == len - 1) w = b;
        else w = recent_window[8*(len-2-i) +: 8];
        if (w != cfg_delim_bytes[8*i +: 8]) hit = 1'b0;
      end
    end
    if (hit) begin
      dstart = p - 16'(len - 1);
      if (in_records) begin
        out_q.push_back(make_result(KIND_FIELD, shown_field(),
                                    in_value ? fld_start : rec_start, dstart - 16'd1, 1'b1,
                                    !in_value || (fld_count + 1 != int'(cfg_schema)), 1'b0));
      end else begin
        first_delim = dstart;
        in_records = 1'b1;
      end
      last_delim = dstart;
      rec_start = p + 16'd1;
      in_value = 1'b0;
      fld_count = 0;
      since_match = 0;
    end else begin
      since_match = cnt;
      if (in_records && cnt >= len) begin
        q = p - 16'(len - 1);
        if (len == 1) c = b;
        else c = recent_window[8*(len-2) +: 8];
        if (!in_value && c == COLON_CHAR) begin
          fld_start = q + 16'd1;
          in_value = 1'b1;
        end else if (in_value && c == COMMA_CHAR) begin
          out_q.push_back(make_result(KIND_FIELD, shown_field(), fld_start, q,
                                      1'b0, 1'b0, 1'b0));
          if (fld_count < MAX_FIELDS) fld_count++;
          in_value = 1'b0;
        end
      end
    end
    recent_window = {recent_window[15:0], b};
    if (it.buffer_end) begin
      if (in_records) begin
        out_q.push_back(make_result(KIND_SUMMARY, '0, first_delim, last_delim,
                                    1'b0, 1'b0, 1'b1));
      end else begin
        out_q.push_back(make_result(KIND_SUMMARY, '0, NO_DELIM_OFFSET, NO_DELIM_OFFSET,
                                    1'b0, 1'b0, 1'b0));
      end
      clear_scan_state();
      buffers_done++;
    end else begin
      scan_pos = p + 16'd1;
    end
    if (out_q.size() != 0) out_q[out_q.size()-1].last_result = 1'b1;
    for (i = 0; i < out_q.size(); i++) expected_results.push_back(out_q[i]);
  endtask

  task automatic report_error(input string msg);
    if (error_count < REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_error({"unexpected result: ", fmt_result(got)});
    end else begin
      want = expected_results.pop_front();
      if (want.record_kind == KIND_SUMMARY) summaries_checked++;
      else fields_checked++;
      if (got.record_kind !== want.record_kind || got.field_number !== want.field_number ||
          got.start_offset !== want.start_offset || got.end_offset !== want.end_offset ||
          got.record_done !== want.record_done || got.count_mismatch !== want.count_mismatch ||
          got.delim_found !== want.delim_found || got.last_result !== want.last_result) begin
        report_error({"result mismatch\n  expected ", fmt_result(want),
                      "\n  actual   ", fmt_result(got)});
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_result(result);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.buffer_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    index_byte(it);
    bytes_sent++;
  endtask

  task automatic send_pending();
    int i;
    for (i = 0; i < pending.size(); i++) send_item(pending[i], i == pending.size() - 1);
  endtask

  task automatic append_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) pending.push_back(s[i]);
  endtask

  task automatic append_delim();
    int i;
    for (i = 0; i < eff_delim_len(); i++) pending.push_back(cfg_delim_bytes[8*i +: 8]);
  endtask

  function automatic logic [7:0] filler_byte();
    int r, k;
    r = $urandom_range(99);
    k = $urandom_range(eff_delim_len() - 1);
    if (r < 3) return COLON_CHAR;
    if (r < 6) return COMMA_CHAR;
    if (r < 10) return cfg_delim_bytes[8*k +: 8];
    if (r < 18) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  task automatic settle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx);
    logic [31:0] want;
    case (idx)
      REG_DELIM_BYTES: want = cfg_delim_bytes;
      REG_DELIM_LEN: want = {29'd0, cfg_delim_len};
      default: want = {25'd0, cfg_schema};
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_error($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DELIM_BYTES: cfg_delim_bytes = value;
      REG_DELIM_LEN: cfg_delim_len = value[2:0];
      default: cfg_schema = value[6:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    reg_check(idx);
  endtask

  task automatic set_config(input logic [31:0] delim, input logic [2:0] len,
                            input logic [6:0] schema);
    settle();
    reg_write(REG_DELIM_BYTES, delim);
    reg_write(REG_DELIM_LEN, {29'd0, len});
    reg_write(REG_SCHEMA_COUNT, {25'd0, schema});
    settings_applied++;
  endtask

  task automatic send_random_buffer();
    int nf, k;
    pending.delete();
    repeat ($urandom_range(3)) pending.push_back(filler_byte());
    if ($urandom_range(9) != 0) append_delim();
    repeat ($urandom_range(1, 4)) begin
      if (cfg_schema >= 1 && cfg_schema <= 6 && $urandom_range(3) != 0) nf = cfg_schema;
      else nf = $urandom_range(1, 6);
      for (k = 0; k < nf; k++) begin
        repeat ($urandom_range(2)) pending.push_back(filler_byte());
        if ($urandom_range(9) != 0) pending.push_back(COLON_CHAR);
        repeat ($urandom_range(3)) pending.push_back(filler_byte());
        if (k < nf - 1) pending.push_back(COMMA_CHAR);
      end
      if ($urandom_range(7) != 0) append_delim();
    end
    repeat ($urandom_range(2)) pending.push_back(filler_byte());
    if (pending.size() == 0) pending.push_back(filler_byte());
    send_pending();
  endtask

  task automatic test_register_access();
    reg_check(REG_DELIM_BYTES);
    reg_check(REG_DELIM_LEN);
    reg_check(REG_SCHEMA_COUNT);
    reg_write(REG_DELIM_BYTES, 32'hFFFF_FFFF);
    reg_write(REG_DELIM_BYTES, 32'h0000_0000);
    reg_write(REG_DELIM_LEN, 32'd0);
    reg_write(REG_DELIM_LEN, 32'd7);
    reg_write(REG_SCHEMA_COUNT, 32'd0);
    reg_write(REG_SCHEMA_COUNT, 32'd127);
    set_config(DELIM_BYTES_RST, DELIM_LEN_RST, SCHEMA_COUNT_RST);
  endtask

  // leading skip, stray comma and inner colon, empty record, record with no colon,
  // field closed at buffer end, buffer without any delimiter
  task automatic test_directed();
    send_idle_pct = 38;
    recv_idle_pct = 78;
    pending.delete();
    pending.push_back(8'hFF);
    append_text("\n,:x:,:");
    pending.push_back(8'h00);
    append_text("\n\nq\nk:v\n");
    send_pending();
    pending.delete();
    pending.push_back(8'h00);
    pending.push_back(8'hFF);
    send_pending();
    settle();
  endtask

  task automatic test_random_records(input int send_pct, input int recv_pct,
                                     input int first_setting);
    int k, start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = first_setting; k < first_setting + 3; k++) begin
      case (k)
        0: set_config(32'h0000_000A, 3'd1, 7'd3);
        1: set_config(32'h0000_0A0D, 3'd2, 7'd2);
        2: set_config(32'h007C_7C7C, 3'd3, 7'd4);
        3: set_config(32'hFFFF_FFFF, 3'd4, 7'd1);
        4: set_config(32'h3A2C_3A2C, 3'd4, 7'd2);
        5: set_config(32'h0000_0000, 3'd0, 7'd0);
        6: set_config(32'hA5C3_5A3C, 3'd7, 7'd127);
        7: set_config(32'h0000_007C, 3'd5, 7'd64);
        default: set_config($urandom, 3'($urandom_range(1, 4)), 7'($urandom_range(1, 6)));
      endcase
      start = bytes_sent;
      while (bytes_sent - start < BYTES_PER_SETTING) send_random_buffer();
    end
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(32'h0000_000A, 3'd1, 7'd40);
    hold_request = 400;
    pending.delete();
    append_text("\n");
    repeat (40) append_text("a:b,");
    append_text("\n");
    send_pending();
    settle();
  endtask

  task automatic test_field_overflow();
    int counts[3];
    int n, f;
    counts = '{63, 64, 66};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(32'h0000_000A, 3'd1, 7'd64);
    pending.delete();
    append_text("\n");
    for (n = 0; n < 3; n++) begin
      for (f = 0; f < counts[n]; f++) begin
        append_text("k:v");
        if (f < counts[n] - 1) append_text(",");
      end
      append_text("\n");
    end
    send_pending();
    settle();
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed();
    test_random_records(38, 78, 0);
    test_random_records(78, 38, 3);
    test_random_records(0, 0, 6);
    test_backpressure();
    test_field_overflow();
    push <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_results.size()));
    $display("Scanned %0d bytes in %0d buffers across %0d register settings,",
             bytes_sent, buffers_done, settings_applied);
    $display("checked %0d field results and %0d buffer summaries, %0d errors.",
             fields_checked, summaries_checked, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
